FILE: hdl/oale_pkg.sv
// Package for the ordered array list engine.
// Holds operation, status, cell and sequencer codes shared by the cell and the top level.
// No dependencies.
package oale_pkg;

	typedef enum logic [2:0] {
		OP_INSERT  = 3'd0,
		OP_DEL_POS = 3'd1,
		OP_DEL_VAL = 3'd2,
		OP_READ    = 3'd3,
		OP_SEARCH  = 3'd4,
		OP_SORT    = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_FULL     = 3'd1,
		STS_EMPTY    = 3'd2,
		STS_BADPOS   = 3'd3,
		STS_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_ROTATE,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_SORT
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t         mode;
		logic               parity;
		logic signed [31:0] value;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SORT,
		S_APPLY
	} seq_state_t;

endpackage

FILE: hdl/oale_cell.sv
// One list cell: holds a single entry and trades it with its two neighbors.
// Depends on oale_pkg for the cell control struct.
module oale_cell
	import oale_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int IDX   = 0
) (
	input  logic                         clk,
	input  cell_ctrl_t                   ctrl,
	input  logic [$clog2(DEPTH)-1:0]     sel_pos,
	input  logic [$clog2(DEPTH+1)-1:0]   count,
	input  logic signed [31:0]           left_data,
	input  logic signed [31:0]           right_data,
	output logic signed [31:0]           data
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] IDX_P    = IW'(IDX);
	localparam logic [CW-1:0] IDX_C    = CW'(IDX);
	localparam logic [CW-1:0] IDX_NEXT = CW'(IDX + 1);
	localparam logic          IS_ODD   = 1'(IDX % 2);
	localparam logic          HAS_LEFT = (IDX > 0);

	logic signed [31:0] data_q;
	logic signed [31:0] data_nxt;
	logic               lower_swap;
	logic               upper_swap;

	assign lower_swap = (IS_ODD == ctrl.parity) && (IDX_NEXT < count) && (data_q > right_data);
	assign upper_swap = HAS_LEFT && (IS_ODD != ctrl.parity) && (IDX_C < count)
		&& (left_data > data_q);

	always_comb begin
		data_nxt = data_q;
		unique case (ctrl.mode)
			CELL_HOLD: data_nxt = data_q;
			CELL_ROTATE: data_nxt = right_data;
			CELL_INSERT: begin
				if (IDX_P > sel_pos) begin
					data_nxt = left_data;
				end else if (IDX_P == sel_pos) begin
					data_nxt = ctrl.value;
				end
			end
			CELL_REMOVE: begin
				if (IDX_P >= sel_pos) begin
					data_nxt = right_data;
				end
			end
			CELL_SORT: begin
				if (lower_swap) begin
					data_nxt = right_data;
				end else if (upper_swap) begin
					data_nxt = left_data;
				end
			end
			default: data_nxt = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data = data_q;

endmodule

FILE: hdl/ordered_array_list_engine_core.sv
// Top level of the ordered array list engine: sequencer, scan accumulators and cell ring.
// Depends on oale_pkg and oale_cell.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------------
//  cfg      | cfg_valid / cfg_ready | cfg_data (capacity)
//  in       | in_valid / in_ready   | operation, position, value, occurrence
//  out      | out_valid / out_ready | status, read_value, found_position, match_count,
//           |                       | length, is_sorted
//
// Insert, reserved codes and any operation on an empty list skip the pass over the cells.
// Delete, delete by value, read and search rotate the cell ring once.
// Sort runs DEPTH odd-even transposition passes over the cells.
// Reset empties the list, clears the sorted flag and sets capacity to 64; entries are undefined.
// A result held back by out_ready low holds the list; the next transaction waits for it.
module ordered_array_list_engine_core
	import oale_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [6:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         operation,
	input  logic [5:0]         position,
	input  logic signed [31:0] value,
	input  logic [6:0]         occurrence,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic signed [31:0] read_value,
	output logic [5:0]         found_position,
	output logic [6:0]         match_count,
	output logic [6:0]         length,
	output logic               is_sorted
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > 7) ? CW : 7;
	localparam logic [IW-1:0] K_LAST = IW'(DEPTH - 1);
	localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

	seq_state_t state_q, state_nxt;

	logic [6:0]         cap_q;
	logic [CW-1:0]      count_q;
	logic               sorted_q;

	op_t                op_q;
	logic [5:0]         pos_q;
	logic signed [31:0] val_q;
	logic [6:0]         occ_q;

	logic [IW-1:0]      k_q;
	logic [CW-1:0]      mcnt_q;
	logic [IW-1:0]      last_q;
	logic [IW-1:0]      occ_pos_q;
	logic signed [31:0] rd_val_q;

	logic               out_valid_q;
	status_t            status_q;
	logic signed [31:0] rval_q;
	logic [5:0]         fpos_q;
	logic [6:0]         mcnt_out_q;
	logic [6:0]         length_q;
	logic               sorted_out_q;

	logic               accept;
	logic               commit;
	logic               out_free;
	op_t                op_in;
	cell_mode_t         cell_mode;
	cell_ctrl_t         ctrl;

	logic [XW-1:0]      pos_x, cnt_x, cap_x, cap_eff, occ_x, mcnt_x;

	status_t            res_status;
	logic signed [31:0] res_rval;
	logic [IW-1:0]      res_fpos;
	logic [CW-1:0]      res_mcnt;
	logic [CW-1:0]      nxt_count;
	logic               nxt_sorted;
	cell_mode_t         res_mode;
	logic [IW-1:0]      res_sel;

	logic signed [31:0] cell_data [DEPTH];
	logic signed [31:0] head;
	logic               in_list;
	logic               hit;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign op_in     = op_t'(operation);

	assign pos_x   = XW'(pos_q);
	assign cnt_x   = XW'(count_q);
	assign cap_x   = XW'(cap_q);
	assign cap_eff = (cap_x > DEPTH_X) ? DEPTH_X : cap_x;
	assign occ_x   = XW'(occ_q);
	assign mcnt_x  = XW'(mcnt_q);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		commit    = 1'b0;
		cell_mode = CELL_HOLD;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (count_q == '0) begin
						state_nxt = S_APPLY;
					end else if (op_in == OP_DEL_POS || op_in == OP_DEL_VAL
						|| op_in == OP_READ || op_in == OP_SEARCH) begin
						state_nxt = S_SCAN;
					end else if (op_in == OP_SORT) begin
						state_nxt = S_SORT;
					end else begin
						state_nxt = S_APPLY;
					end
				end
			end
			S_SCAN: begin
				cell_mode = CELL_ROTATE;
				if (k_q == K_LAST) begin
					state_nxt = S_APPLY;
				end
			end
			S_SORT: begin
				cell_mode = CELL_SORT;
				if (k_q == K_LAST) begin
					state_nxt = S_APPLY;
				end
			end
			S_APPLY: begin
				if (out_free) begin
					commit    = 1'b1;
					cell_mode = res_mode;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Result and list update
	always_comb begin
		res_status = STS_OK;
		res_rval   = '0;
		res_fpos   = '0;
		res_mcnt   = '0;
		nxt_count  = count_q;
		nxt_sorted = sorted_q;
		res_mode   = CELL_HOLD;
		res_sel    = '0;
		unique case (op_q)
			OP_INSERT: begin
				if (cnt_x >= cap_eff) begin
					res_status = STS_FULL;
				end else if (pos_x > cnt_x) begin
					res_status = STS_BADPOS;
				end else begin
					res_mode   = CELL_INSERT;
					res_sel    = IW'(pos_q);
					nxt_count  = count_q + 1'b1;
					nxt_sorted = 1'b0;
				end
			end
			OP_DEL_POS: begin
				if (count_q == '0) begin
					res_status = STS_EMPTY;
				end else if (pos_x >= cnt_x) begin
					res_status = STS_BADPOS;
				end else begin
					res_rval  = rd_val_q;
					res_fpos  = IW'(pos_q);
					res_mode  = CELL_REMOVE;
					res_sel   = IW'(pos_q);
					nxt_count = count_q - 1'b1;
				end
			end
			OP_DEL_VAL, OP_SEARCH: begin
				if (count_q == '0) begin
					res_status = STS_EMPTY;
				end else if (mcnt_q == '0) begin
					res_status = STS_NOTFOUND;
				end else begin
					res_mcnt = mcnt_q;
					if (op_q == OP_SEARCH) begin
						res_rval = val_q;
						res_fpos = last_q;
					end else if (mcnt_q == count_q) begin
						nxt_count = '0;
					end else if (mcnt_q == CW'(1)) begin
						res_rval  = val_q;
						res_fpos  = last_q;
						res_mode  = CELL_REMOVE;
						res_sel   = last_q;
						nxt_count = count_q - 1'b1;
					end else if (occ_x == '0 || occ_x > mcnt_x) begin
						res_status = STS_BADPOS;
					end else begin
						res_rval  = val_q;
						res_fpos  = occ_pos_q;
						res_mode  = CELL_REMOVE;
						res_sel   = occ_pos_q;
						nxt_count = count_q - 1'b1;
					end
				end
			end
			OP_READ: begin
				if (count_q == '0) begin
					res_status = STS_EMPTY;
				end else if (pos_x >= cnt_x) begin
					res_status = STS_BADPOS;
				end else begin
					res_rval = rd_val_q;
				end
			end
			OP_SORT: begin
				if (count_q == '0) begin
					res_status = STS_EMPTY;
				end else begin
					nxt_sorted = 1'b1;
				end
			end
			default: res_status = STS_OK;
		endcase
	end

	// Configuration and list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= 7'd64;
			count_q  <= '0;
			sorted_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (commit) begin
				count_q  <= nxt_count;
				sorted_q <= nxt_sorted;
			end
		end
	end

	// Transaction latch and scan accumulators
	assign head    = cell_data[0];
	assign in_list = CW'(k_q) < count_q;
	assign hit     = in_list && (head == val_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op_in;
			pos_q     <= position;
			val_q     <= value;
			occ_q     <= occurrence;
			k_q       <= '0;
			mcnt_q    <= '0;
			last_q    <= '0;
			occ_pos_q <= '0;
			rd_val_q  <= '0;
		end else if (state_q == S_SCAN || state_q == S_SORT) begin
			k_q <= k_q + 1'b1;
			if (state_q == S_SCAN) begin
				if (hit) begin
					mcnt_q <= mcnt_q + 1'b1;
					last_q <= k_q;
					if (mcnt_x + 1'b1 == occ_x) begin
						occ_pos_q <= k_q;
					end
				end
				if (XW'(k_q) == pos_x) begin
					rd_val_q <= head;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q     <= res_status;
			rval_q       <= res_rval;
			fpos_q       <= 6'(res_fpos);
			mcnt_out_q   <= 7'(res_mcnt);
			length_q     <= 7'(nxt_count);
			sorted_out_q <= nxt_sorted;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign read_value     = rval_q;
	assign found_position = fpos_q;
	assign match_count    = mcnt_out_q;
	assign length         = length_q;
	assign is_sorted      = sorted_out_q;

	// Cell ring
	assign ctrl.mode   = cell_mode;
	assign ctrl.parity = k_q[0];
	assign ctrl.value  = val_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		oale_cell #(
			.DEPTH (DEPTH),
			.IDX   (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.sel_pos    (res_sel),
			.count      (count_q),
			.left_data  (cell_data[(i + DEPTH - 1) % DEPTH]),
			.right_data (cell_data[(i + 1) % DEPTH]),
			.data       (cell_data[i])
		);
	end

	assert property (@(posedge clk) disable iff (!arst_n) commit |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle after commit");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && k_q == K_LAST) |=> state_q == S_APPLY)
		else $error("scan did not end after one full rotation");

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(commit && res_mode == CELL_INSERT) |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the list by one");

	assert property (@(posedge clk) disable iff (!arst_n)
		(commit && res_mode == CELL_REMOVE) |=> count_q == $past(count_q) - 1'b1)
		else $error("remove did not shrink the list by one");

endmodule

FILE: dv/ordered_array_list_engine_core_tb.sv
// Testbench for ordered_array_list_engine_core: directed table, then random phases across capacities.
// Expected results come from a list model or the directed table, scored in order at the output.
// Depends on oale_pkg and the engine RTL.
module ordered_array_list_engine_core_tb;
	import oale_pkg::*;

	localparam int DEPTH = 64;
	localparam int IDLE_LIMIT = 2000;
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;
	localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
	localparam int PHASE_COUNT = 7;
	localparam int PHASE_CAP [PHASE_COUNT] = '{64, 1, 0, 127, 8, 3, 64};
	localparam int PHASE_ITEMS [PHASE_COUNT] = '{160, 40, 20, 120, 80, 60, 170};
	localparam int PHASE_INS [PHASE_COUNT] = '{65, 40, 40, 55, 35, 35, 30};

	typedef struct {
		status_t            st;
		logic signed [31:0] rval;
		logic [5:0]         fpos;
		logic [6:0]         mcnt;
		logic [6:0]         len;
		logic               srt;
	} list_result_t;

	typedef struct {
		logic [2:0]         op;
		logic [5:0]         pos;
		logic signed [31:0] val;
		logic [6:0]         occ;
		bit                 typed;
		list_result_t       want;
	} list_step_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [6:0]         cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         operation = '0;
	logic [5:0]         position = '0;
	logic signed [31:0] value = '0;
	logic [6:0]         occurrence = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         status;
	logic signed [31:0] read_value;
	logic [5:0]         found_position;
	logic [6:0]         match_count;
	logic [6:0]         length;
	logic               is_sorted;

	logic signed [31:0] list_words [DEPTH];
	int                 list_len = 0;
	bit                 list_sorted = 1'b0;
	int                 cap_setting = 64;

	list_result_t       result_q [$];
	list_step_t         plan [$];
	int                 mismatches = 0;
	int                 results_seen = 0;
	int                 idle_cycles = 0;
	int                 stall_left = 0;
	bit                 calm = 1'b0;

	ordered_array_list_engine_core #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.position(position),
		.value(value),
		.occurrence(occurrence),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.read_value(read_value),
		.found_position(found_position),
		.match_count(match_count),
		.length(length),
		.is_sorted(is_sorted)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH %s", msg);
		mismatches++;
	endtask

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [31:0] take_word(input int at);
		logic signed [31:0] gone;
		gone = list_words[at];
		for (int i = at; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
		list_len--;
		return gone;
	endfunction

	function automatic list_result_t predict_list(input logic [2:0] op, input logic [5:0] pos,
			input logic signed [31:0] val, input logic [6:0] occ);
		list_result_t r;
		int eff_cap;
		int hits;
		int last_hit;
		int nth;
		int k;
		logic signed [31:0] t;
		r = '{st: STS_OK, rval: '0, fpos: '0, mcnt: '0, len: '0, srt: 1'b0};
		eff_cap = (cap_setting > DEPTH) ? DEPTH : cap_setting;
		unique case (op)
			OP_INSERT: begin
				if (list_len >= eff_cap) begin
					r.st = STS_FULL;
				end else if (pos > list_len) begin
					r.st = STS_BADPOS;
				end else begin
					for (int i = list_len; i > pos; i--) list_words[i] = list_words[i - 1];
					list_words[pos] = val;
					list_len++;
					list_sorted = 1'b0;
				end
			end
			OP_DEL_POS: begin
				if (list_len == 0) begin
					r.st = STS_EMPTY;
				end else if (pos >= list_len) begin
					r.st = STS_BADPOS;
				end else begin
					r.rval = take_word(pos);
					r.fpos = pos;
				end
			end
			OP_DEL_VAL, OP_SEARCH: begin
				if (list_len == 0) begin
					r.st = STS_EMPTY;
				end else begin
					hits = 0;
					last_hit = 0;
					for (int i = 0; i < list_len; i++) begin
						if (list_words[i] == val) begin
							hits++;
							last_hit = i;
						end
					end
					r.mcnt = 7'(hits);
					if (hits == 0) begin
						r.st = STS_NOTFOUND;
					end else if (op == OP_SEARCH) begin
						r.rval = val;
						r.fpos = 6'(last_hit);
					end else if (hits == list_len) begin
						list_len = 0;
					end else if (hits == 1) begin
						r.fpos = 6'(last_hit);
						r.rval = take_word(last_hit);
					end else if (occ == 0 || occ > hits) begin
						r.st = STS_BADPOS;
					end else begin
						nth = 0;
						k = 0;
						for (int i = 0; i < list_len; i++) begin
							if (list_words[i] == val) begin
								nth++;
								if (nth == occ) begin
									k = i;
									break;
								end
							end
						end
						r.fpos = 6'(k);
						r.rval = take_word(k);
					end
				end
			end
			OP_READ: begin
				if (list_len == 0) r.st = STS_EMPTY;
				else if (pos >= list_len) r.st = STS_BADPOS;
				else r.rval = list_words[pos];
			end
			OP_SORT: begin
				if (list_len == 0) begin
					r.st = STS_EMPTY;
				end else begin
					for (int j = 0; j < list_len; j++) begin
						for (int i = 0; i + 1 < list_len; i++) begin
							if (list_words[i] > list_words[i + 1]) begin
								t = list_words[i];
								list_words[i] = list_words[i + 1];
								list_words[i + 1] = t;
							end
						end
					end
					list_sorted = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.len = 7'(list_len);
		r.srt = list_sorted;
		return r;
	endfunction

	task automatic push_item(input logic [2:0] op, input logic [5:0] pos,
			input logic signed [31:0] val, input logic [6:0] occ,
			input bit typed, input list_result_t typed_want);
		list_result_t predicted;
		int gap;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		position <= pos;
		value <= val;
		occurrence <= occ;
		do @(posedge clk); while (!in_ready);
		predicted = predict_list(op, pos, val, occ);
		result_q.push_back(typed ? typed_want : predicted);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [6:0] cap);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_setting = int'(cap);
	endtask

	task automatic plan_step(input logic [2:0] op, input logic [5:0] pos,
			input logic signed [31:0] val, input logic [6:0] occ, input bit typed,
			input status_t st, input logic [6:0] len, input logic srt);
		list_step_t s;
		s.op = op;
		s.pos = pos;
		s.val = val;
		s.occ = occ;
		s.typed = typed;
		s.want = '{st: st, rval: '0, fpos: '0, mcnt: '0, len: len, srt: srt};
		plan.push_back(s);
	endtask

	task automatic random_item(input int ins_weight);
		logic [2:0] op;
		logic [5:0] pos;
		logic signed [31:0] val;
		logic [6:0] occ;
		list_result_t none;
		int pick;
		int lim;
		none = '{st: STS_OK, rval: '0, fpos: '0, mcnt: '0, len: '0, srt: 1'b0};
		pick = $urandom_range(0, 99);
		if (pick < ins_weight) begin
			op = OP_INSERT;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 18) op = OP_DEL_POS;
			else if (pick < 38) op = OP_DEL_VAL;
			else if (pick < 60) op = OP_READ;
			else if (pick < 82) op = OP_SEARCH;
			else if (pick < 94) op = OP_SORT;
			else op = 3'($urandom_range(OP_RSVD6, OP_RSVD7));
		end
		lim = (list_len > 63) ? 63 : list_len;
		pos = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, lim)) : 6'($urandom_range(0, 63));
		pick = $urandom_range(0, 9);
		if (pick < 4 && list_len > 0) val = list_words[$urandom_range(0, list_len - 1)];
		else if (pick < 7) val = int'($urandom_range(0, 4)) - 2;
		else if (pick == 7) val = $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
		else val = $urandom;
		occ = ($urandom_range(0, 6) != 0) ? 7'($urandom_range(0, 4)) : 7'($urandom_range(0, 127));
		push_item(op, pos, val, occ, 1'b0, none);
	endtask

	always @(posedge clk) begin
		int n;
		if (calm) begin
			stall_left <= 0;
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			n = idle_len();
			stall_left <= n;
			out_ready <= (n == 0);
		end
	end

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
			end else begin
				want = result_q.pop_front();
				if (status !== want.st)
					report_mismatch($sformatf("result %0d status %0d, expected %0d",
						results_seen, status, want.st));
				if (read_value !== want.rval)
					report_mismatch($sformatf("result %0d read_value %0d, expected %0d",
						results_seen, read_value, want.rval));
				if (found_position !== want.fpos)
					report_mismatch($sformatf("result %0d found_position %0d, expected %0d",
						results_seen, found_position, want.fpos));
				if (match_count !== want.mcnt)
					report_mismatch($sformatf("result %0d match_count %0d, expected %0d",
						results_seen, match_count, want.mcnt));
				if (length !== want.len)
					report_mismatch($sformatf("result %0d length %0d, expected %0d",
						results_seen, length, want.len));
				if (is_sorted !== want.srt)
					report_mismatch($sformatf("result %0d is_sorted %0d, expected %0d",
						results_seen, is_sorted, want.srt));
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		for (int i = 0; i < DEPTH; i++) list_words[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan_step(OP_READ, 6'd0, 32'sd0, 7'd0, 1'b1, STS_EMPTY, 7'd0, 1'b0);
		plan_step(OP_DEL_POS, 6'd0, 32'sd0, 7'd0, 1'b1, STS_EMPTY, 7'd0, 1'b0);
		plan_step(OP_DEL_VAL, 6'd0, 32'sd5, 7'd1, 1'b1, STS_EMPTY, 7'd0, 1'b0);
		plan_step(OP_SEARCH, 6'd0, 32'sd5, 7'd0, 1'b1, STS_EMPTY, 7'd0, 1'b0);
		plan_step(OP_SORT, 6'd0, 32'sd0, 7'd0, 1'b1, STS_EMPTY, 7'd0, 1'b0);
		plan_step(OP_INSERT, 6'd1, 32'sd7, 7'd0, 1'b1, STS_BADPOS, 7'd0, 1'b0);
		plan_step(OP_INSERT, 6'd0, WORD_MAX, 7'd0, 1'b1, STS_OK, 7'd1, 1'b0);
		plan_step(OP_INSERT, 6'd0, WORD_MIN, 7'd0, 1'b1, STS_OK, 7'd2, 1'b0);
		plan_step(OP_INSERT, 6'd2, 32'sd0, 7'd0, 1'b1, STS_OK, 7'd3, 1'b0);
		plan_step(OP_INSERT, 6'd1, -32'sd1, 7'd0, 1'b0, STS_OK, 7'd0, 1'b0);
		plan_step(OP_READ, 6'd3, 32'sd0, 7'd0, 1'b0, STS_OK, 7'd0, 1'b0);
		plan_step(OP_READ, 6'd4, 32'sd0, 7'd0, 1'b1, STS_BADPOS, 7'd4, 1'b0);
		plan_step(OP_DEL_POS, 6'd63, 32'sd0, 7'd0, 1'b1, STS_BADPOS, 7'd4, 1'b0);
		plan_step(OP_SORT, 6'd0, 32'sd0, 7'd0, 1'b0, STS_OK, 7'd0, 1'b0);
		plan_step(OP_INSERT, 6'd4, -32'sd1, 7'd0, 1'b0, STS_OK, 7'd0, 1'b0);
		plan_step(OP_SEARCH, 6'd0, -32'sd1, 7'd0, 1'b0, STS_OK, 7'd0, 1'b0);
		plan_step(OP_SEARCH, 6'd0, 32'sd12345, 7'd0, 1'b1, STS_NOTFOUND, 7'd5, 1'b0);
		plan_step(OP_DEL_VAL, 6'd0, -32'sd1, 7'd0, 1'b0, STS_OK, 7'd0, 1'b0);
		plan_step(OP_DEL_VAL, 6'd0, -32'sd1, 7'd3, 1'b0, STS_OK, 7'd0, 1'b0);
		plan_step(OP_DEL_VAL, 6'd0, -32'sd1, 7'd2, 1'b0, STS_OK, 7'd0, 1'b0);
		plan_step(OP_DEL_VAL, 6'd0, WORD_MAX, 7'h7f, 1'b0, STS_OK, 7'd0, 1'b0);
		plan_step(OP_RSVD7, 6'h3f, -32'sd1, 7'h7f, 1'b0, STS_OK, 7'd0, 1'b0);
		plan_step(OP_DEL_POS, 6'd0, 32'sd0, 7'd0, 1'b0, STS_OK, 7'd0, 1'b0);
		plan_step(OP_DEL_POS, 6'd1, 32'sd0, 7'd0, 1'b0, STS_OK, 7'd0, 1'b0);
		plan_step(OP_DEL_VAL, 6'd0, -32'sd1, 7'd1, 1'b0, STS_OK, 7'd0, 1'b0);

		foreach (plan[i])
			push_item(plan[i].op, plan[i].pos, plan[i].val, plan[i].occ, plan[i].typed, plan[i].want);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_capacity(7'(PHASE_CAP[p]));
			for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
				calm <= ((n % 90) < 15);
				if (n == PHASE_ITEMS[p] / 2 && p == 3) drain_results();
				random_item(PHASE_INS[p]);
			end
		end

		drain_results();
		repeat (DEPTH + 8) @(posedge clk);
		if (mismatches == 0 && result_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
